// ===== hdl/lch_pkg.sv =====
`default_nettype none

package lch_pkg;

  localparam int LEVELS     = 8;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int CNT_W      = 32;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 13;
  localparam int NEIGHBORS  = 8;
  localparam int NB_W       = $clog2(NEIGHBORS + 1);
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] MIN_DIM        = DIM_W'(3);
  localparam logic [DIM_W-1:0] WIDTH_LIMIT    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_LIMIT   = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] RESET_WIDTH    = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT   = DIM_W'(480);

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [LVL_W-1:0]  level_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [LEVELS-1:0][CNT_W-1:0] row_t;
  typedef logic [LEVELS-1:0][NB_W-1:0]  inc_t;

  localparam kind_t KIND_PIXEL = 2'd0;
  localparam kind_t KIND_PAIR  = 2'd1;
  localparam kind_t KIND_HIST  = 2'd2;
  localparam kind_t KIND_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic wr;
    logic clr;
  } bank_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < MIN_DIM) r = MIN_DIM;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lch_pair_bank.sv =====
`default_nettype none

module lch_pair_bank (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire lch_pkg::level_t    rd_row,
  input  wire lch_pkg::bank_ctl_t ctl,
  input  wire lch_pkg::inc_t      inc,
  output lch_pkg::row_t           row_data
);

  lch_pkg::row_t   mem [lch_pkg::LEVELS];
  lch_pkg::row_t   rd_q;
  lch_pkg::level_t rd_row_q;
  lch_pkg::row_t   fwd_data;
  lch_pkg::level_t fwd_row;
  logic            fwd;
  logic [lch_pkg::LEVELS-1:0] vld;
  lch_pkg::row_t   upd;

  // row being read was written at the same edge: take the written copy
  always_comb begin
    if (!vld[rd_row_q]) begin
      row_data = '0;
    end else if (fwd && (fwd_row == rd_row_q)) begin
      row_data = fwd_data;
    end else begin
      row_data = rd_q;
    end
  end

  always_comb begin
    logic [lch_pkg::CNT_W:0] sum;
    upd = '0;
    for (int l = 0; l < lch_pkg::LEVELS; l++) begin
      sum = {1'b0, row_data[l]} + (lch_pkg::CNT_W + 1)'(inc[l]);
      upd[l] = sum[lch_pkg::CNT_W] ? {lch_pkg::CNT_W{1'b1}} : sum[lch_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_q <= mem[rd_row];
      if (ctl.wr) begin
        mem[rd_row_q] <= upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_row_q <= rd_row;
      if (ctl.wr) begin
        fwd_data <= upd;
        fwd_row  <= rd_row_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      fwd <= 1'b0;
    end else if (en) begin
      fwd <= ctl.wr;
      if (ctl.clr) begin
        vld <= '0;
      end else if (ctl.wr) begin
        vld[rd_row_q] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/label_cooccurrence_histogram_core.sv =====
// Label co-occurrence histogram over a raster stream of 3-bit labels.
// Input channel (in_valid / in_stall): kind selects a pixel, a pair count
// read, a histogram bin read or a clear of all counts. Only the two read
// kinds return an item on the output channel (out_valid / out_stall) with
// read_value, pixel_total and frame_complete.
// One item is accepted per cycle while in_stall is low; a read result passes
// stage 1, stage 2 and the output register. The pipeline is accept / line
// store read, window and pair row read, read-modify-write of the pair row;
// the pair row memory forwards the row written in the previous cycle.
// The output register holds a result while out_stall is high; pixels and
// clears keep flowing, and the input stalls only when a second read result
// reaches the last stage with the output register still held.
// Config port (cfg_valid / cfg_ready, always ready): index 0 image width,
// index 1 image height, clamped to 3..4096; a write restarts the raster at
// row 0, column 0. Write only while the block is idle.
// Reset restores 640 x 480, clears all counts, the window and the raster
// position. The line stores are not cleared; no clearing pass is needed.
`default_nettype none

module label_cooccurrence_histogram_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lch_pkg::kind_t                  kind,
  input  wire lch_pkg::level_t                 pixel_label,
  input  wire lch_pkg::level_t                 pair_center,
  input  wire lch_pkg::level_t                 pair_neighbor,
  input  wire lch_pkg::level_t                 hist_bin,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output lch_pkg::count_t                      read_value,
  output lch_pkg::count_t                      pixel_total,
  output logic                                 frame_complete,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lch_pkg::DIM_W-1:0]       cfg_data
);

  logic en;
  logic accept;
  logic cfg_wr;

  logic [lch_pkg::DIM_W-1:0] width;
  logic [lch_pkg::DIM_W-1:0] height;
  logic [lch_pkg::COL_W-1:0] col;
  logic [lch_pkg::ROW_W-1:0] row;
  logic col_last;
  logic row_last;
  logic interior;

  logic [2*lch_pkg::LVL_W-1:0] line_mem [lch_pkg::MAX_WIDTH];
  logic [2*lch_pkg::LVL_W-1:0] line_q;
  logic line_we;

  logic                      s1_valid;
  lch_pkg::kind_t            s1_kind;
  lch_pkg::level_t           s1_label;
  lch_pkg::level_t           s1_pc;
  lch_pkg::level_t           s1_pn;
  lch_pkg::level_t           s1_hb;
  logic                      s1_interior;
  logic                      s1_frame_end;
  logic [lch_pkg::COL_W-1:0] s1_col;

  lch_pkg::level_t win [6];
  lch_pkg::level_t top;
  lch_pkg::level_t mid;
  lch_pkg::level_t nbs [lch_pkg::NEIGHBORS];
  lch_pkg::inc_t   nb_cnt;
  lch_pkg::level_t pair_row;

  logic            s2_valid;
  lch_pkg::kind_t  s2_kind;
  lch_pkg::level_t s2_label;
  lch_pkg::level_t s2_pn;
  lch_pkg::level_t s2_hb;
  logic            s2_interior;
  logic            s2_frame_end;
  lch_pkg::inc_t   s2_inc;
  logic            s2_emits;

  lch_pkg::bank_ctl_t bank_ctl;
  lch_pkg::row_t      row_data;

  lch_pkg::count_t lvl [lch_pkg::LEVELS];
  lch_pkg::count_t pix;
  logic            frame_flag;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  assign s2_emits = s2_valid && ((s2_kind == lch_pkg::KIND_PAIR) ||
                                 (s2_kind == lch_pkg::KIND_HIST));
  assign en       = !(out_valid && out_stall && s2_emits);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // raster position
  assign col_last = (({1'b0, col} + lch_pkg::DIM_W'(1)) == width);
  assign row_last = (({1'b0, row} + lch_pkg::DIM_W'(1)) == height);
  assign interior = (col >= lch_pkg::COL_W'(2)) && (row >= lch_pkg::ROW_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= lch_pkg::RESET_WIDTH;
      height <= lch_pkg::RESET_HEIGHT;
      col    <= '0;
      row    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        lch_pkg::CFG_WIDTH: begin
          width <= lch_pkg::clamp_dim(cfg_data, lch_pkg::WIDTH_LIMIT);
          col   <= '0;
          row   <= '0;
        end
        lch_pkg::CFG_HEIGHT: begin
          height <= lch_pkg::clamp_dim(cfg_data, lch_pkg::HEIGHT_LIMIT);
          col    <= '0;
          row    <= '0;
        end
        default: ;
      endcase
    end else if (accept && (kind == lch_pkg::KIND_PIXEL)) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + lch_pkg::ROW_W'(1);
      end else begin
        col <= col + lch_pkg::COL_W'(1);
      end
    end
  end

  // line stores: {upper, middle} per column
  assign line_we = en && s1_valid && (s1_kind == lch_pkg::KIND_PIXEL);
  assign top     = line_q[2*lch_pkg::LVL_W-1:lch_pkg::LVL_W];
  assign mid     = line_q[lch_pkg::LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      line_q <= line_mem[col];
    end
    if (line_we) begin
      line_mem[s1_col] <= {mid, s1_label};
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind      <= kind;
      s1_label     <= pixel_label;
      s1_pc        <= pair_center;
      s1_pn        <= pair_neighbor;
      s1_hb        <= hist_bin;
      s1_interior  <= interior;
      s1_frame_end <= col_last && row_last;
      s1_col       <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (line_we) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= top;
      win[1] <= mid;
      win[2] <= s1_label;
    end
  end

  always_comb begin
    nbs[0] = win[0];
    nbs[1] = win[2];
    nbs[2] = win[3];
    nbs[3] = win[4];
    nbs[4] = win[5];
    nbs[5] = top;
    nbs[6] = mid;
    nbs[7] = s1_label;
  end

  always_comb begin
    nb_cnt = '0;
    for (int l = 0; l < lch_pkg::LEVELS; l++) begin
      for (int k = 0; k < lch_pkg::NEIGHBORS; k++) begin
        nb_cnt[l] = nb_cnt[l] + lch_pkg::NB_W'(nbs[k] == lch_pkg::level_t'(l));
      end
    end
  end

  assign pair_row = (s1_kind == lch_pkg::KIND_PIXEL) ? win[1] : s1_pc;

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind      <= s1_kind;
      s2_label     <= s1_label;
      s2_pn        <= s1_pn;
      s2_hb        <= s1_hb;
      s2_interior  <= s1_interior;
      s2_frame_end <= s1_frame_end;
      s2_inc       <= nb_cnt;
    end
  end

  assign bank_ctl.wr  = s2_valid && (s2_kind == lch_pkg::KIND_PIXEL) && s2_interior;
  assign bank_ctl.clr = s2_valid && (s2_kind == lch_pkg::KIND_CLEAR);

  lch_pair_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rd_row   (pair_row),
    .ctl      (bank_ctl),
    .inc      (s2_inc),
    .row_data (row_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lch_pkg::LEVELS; i++) begin
        lvl[i] <= '0;
      end
      pix        <= '0;
      frame_flag <= 1'b0;
    end else begin
      if (cfg_wr && ((cfg_index == lch_pkg::CFG_WIDTH) ||
                     (cfg_index == lch_pkg::CFG_HEIGHT))) begin
        frame_flag <= 1'b0;
      end
      if (en && s2_valid) begin
        unique case (s2_kind)
          lch_pkg::KIND_PIXEL: begin
            for (int i = 0; i < lch_pkg::LEVELS; i++) begin
              if ((s2_label == lch_pkg::level_t'(i)) && (lvl[i] != '1)) begin
                lvl[i] <= lvl[i] + lch_pkg::CNT_W'(1);
              end
            end
            if (pix != '1) begin
              pix <= pix + lch_pkg::CNT_W'(1);
            end
            frame_flag <= s2_frame_end;
          end
          lch_pkg::KIND_CLEAR: begin
            for (int i = 0; i < lch_pkg::LEVELS; i++) begin
              lvl[i] <= '0;
            end
            pix <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && s2_emits) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_emits) begin
      read_value     <= (s2_kind == lch_pkg::KIND_PAIR) ? row_data[s2_pn] : lvl[s2_hb];
      pixel_total    <= pix;
      frame_complete <= frame_flag;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col} < width))
    else $error("column position beyond image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, row} < height))
    else $error("row position beyond image height");

  a_bank_ctl: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bank_ctl))
    else $error("pair bank write and clear at once");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == lch_pkg::KIND_PIXEL) && col_last && row_last)
      |=> ((col == '0) && (row == '0)))
    else $error("raster did not wrap at end of frame");

endmodule

`default_nettype wire
